### rtl/core/pwt_pkg.sv
package pwt_pkg;

  localparam int LEVELS     = 4;
  localparam int INDEX_BITS = 9;
  localparam int LVL_W      = (LEVELS > 4) ? 3 : 2;
  localparam int PAGE_SHIFT = 12;
  localparam int QDEPTH     = 2;

  localparam logic [63:0] FRAME_MASK  = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] TABLE_FLAGS = 64'd7;

  localparam logic [2:0] OP_TRANSLATE = 3'd0;
  localparam logic [2:0] OP_MAP       = 3'd1;
  localparam logic [2:0] OP_UNMAP     = 3'd2;
  localparam logic [2:0] OP_RD_RESP   = 3'd3;
  localparam logic [2:0] OP_ALLOC     = 3'd4;

  localparam logic [2:0] K_READ  = 3'd0;
  localparam logic [2:0] K_WRITE = 3'd1;
  localparam logic [2:0] K_ALLOC = 3'd2;
  localparam logic [2:0] K_CLEAR = 3'd3;
  localparam logic [2:0] K_DONE  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMAP  = 2'd1;
  localparam logic [1:0] ST_NOMEM  = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [51:0] mem_addr;
    logic [63:0] write_data;
    logic [51:0] result_addr;
    logic [1:0]  status;
  } result_t;

  // cnt: number of results (0..3); r[0] goes out first
  typedef struct packed {
    logic [1:0]       cnt;
    result_t [2:0]    r;
  } cmd_t;

  function automatic logic [51:0] entry_at(input logic [51:0] base,
                                           input logic [47:0] virt,
                                           input logic [LVL_W-1:0] lvl);
    logic [63:0]            v;
    logic [INDEX_BITS-1:0]  idx;
    v   = {16'b0, virt};
    idx = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (lvl == LVL_W'(l))
        idx = v[PAGE_SHIFT + INDEX_BITS*(LEVELS-1-l) +: INDEX_BITS];
    end
    return base + {40'b0, idx, 3'b0};
  endfunction

  function automatic result_t mk(input logic [2:0] kind, input logic [51:0] addr,
                                 input logic [63:0] data, input logic [51:0] res,
                                 input logic [1:0] status);
    result_t x;
    x.kind        = kind;
    x.mem_addr    = addr;
    x.write_data  = data;
    x.result_addr = res;
    x.status      = status;
    return x;
  endfunction

endpackage

### rtl/core/pwt_front.sv
module pwt_front import pwt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [2:0]  op,
  input  logic [51:0] root_table,
  input  logic [47:0] virt_addr,
  input  logic [51:0] phys_addr,
  input  logic [63:0] entry_flags,
  input  logic [63:0] read_data,
  input  logic [51:0] alloc_page,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  logic             busy, busy_next;
  logic [1:0]       pending_op, pending_op_next;
  logic [LVL_W-1:0] walk_level, walk_level_next;
  logic             awaiting_alloc, awaiting_alloc_next;
  logic [47:0]      saved_virt, saved_virt_next;
  logic [51:0]      saved_phys, saved_phys_next;
  logic [63:0]      saved_flags, saved_flags_next;
  logic [51:0]      entry_addr, entry_addr_next;

  logic [LVL_W-1:0] lvl_inc;
  logic [51:0]      req_addr, down_rd, down_alloc, base_rd, base_alloc;
  logic [63:0]      leaf_val, alloc_val;

  assign lvl_inc    = walk_level + LVL_W'(1);
  assign req_addr   = entry_at(root_table, virt_addr, '0);
  assign base_rd    = {read_data[51:12], 12'b0};
  assign base_alloc = {alloc_page[51:12], 12'b0};
  assign down_rd    = entry_at(base_rd, saved_virt, lvl_inc);
  assign down_alloc = entry_at(base_alloc, saved_virt, lvl_inc);
  assign leaf_val   = (pending_op == OP_MAP[1:0]) ?
                      (({12'b0, saved_phys} & FRAME_MASK) | saved_flags) : 64'd0;
  assign alloc_val  = {12'b0, alloc_page} | TABLE_FLAGS;

  always_comb begin
    busy_next           = busy;
    pending_op_next     = pending_op;
    walk_level_next     = walk_level;
    awaiting_alloc_next = awaiting_alloc;
    saved_virt_next     = saved_virt;
    saved_phys_next     = saved_phys;
    saved_flags_next    = saved_flags;
    entry_addr_next     = entry_addr;
    cmd                 = '0;
    case (op) inside
      OP_TRANSLATE, OP_MAP, OP_UNMAP: begin
        if (!busy) begin
          busy_next           = 1'b1;
          awaiting_alloc_next = 1'b0;
          pending_op_next     = op[1:0];
          saved_virt_next     = virt_addr;
          saved_phys_next     = phys_addr;
          saved_flags_next    = entry_flags;
          walk_level_next     = '0;
          entry_addr_next     = req_addr;
          cmd.cnt             = 2'd1;
          cmd.r[0]            = mk(K_READ, req_addr, '0, '0, ST_OK);
        end
      end
      OP_RD_RESP: begin
        if (busy && !awaiting_alloc) begin
          if (walk_level == LVL_W'(LEVELS-1)) begin
            if (pending_op == OP_TRANSLATE[1:0]) begin
              cmd.cnt = 2'd1;
              if (read_data[0])
                cmd.r[0] = mk(K_DONE, '0, '0, {read_data[51:12], saved_virt[11:0]}, ST_OK);
              else
                cmd.r[0] = mk(K_DONE, '0, '0, '0, ST_NOMAP);
            end else begin
              cmd.cnt  = 2'd2;
              cmd.r[0] = mk(K_WRITE, entry_addr, leaf_val, '0, ST_OK);
              cmd.r[1] = mk(K_DONE, '0, '0, '0, ST_OK);
            end
            busy_next = 1'b0;
          end else if (read_data[0]) begin
            walk_level_next = lvl_inc;
            entry_addr_next = down_rd;
            cmd.cnt         = 2'd1;
            cmd.r[0]        = mk(K_READ, down_rd, '0, '0, ST_OK);
          end else if (pending_op == OP_MAP[1:0]) begin
            awaiting_alloc_next = 1'b1;
            cmd.cnt             = 2'd1;
            cmd.r[0]            = mk(K_ALLOC, '0, '0, '0, ST_OK);
          end else begin
            busy_next = 1'b0;
            cmd.cnt   = 2'd1;
            cmd.r[0]  = mk(K_DONE, '0, '0, '0, ST_NOMAP);
          end
        end
      end
      OP_ALLOC: begin
        if (busy && awaiting_alloc) begin
          awaiting_alloc_next = 1'b0;
          if (alloc_page == '0) begin
            busy_next = 1'b0;
            cmd.cnt   = 2'd1;
            cmd.r[0]  = mk(K_DONE, '0, '0, '0, ST_NOMEM);
          end else begin
            walk_level_next = lvl_inc;
            entry_addr_next = down_alloc;
            cmd.cnt         = 2'd3;
            cmd.r[0]        = mk(K_CLEAR, alloc_page, '0, '0, ST_OK);
            cmd.r[1]        = mk(K_WRITE, entry_addr, alloc_val, '0, ST_OK);
            cmd.r[2]        = mk(K_READ, down_alloc, '0, '0, ST_OK);
          end
        end
      end
      default: ;
    endcase
  end

  assign cmd_valid = accept && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      pending_op     <= '0;
      walk_level     <= '0;
      awaiting_alloc <= 1'b0;
    end else if (accept) begin
      busy           <= busy_next;
      pending_op     <= pending_op_next;
      walk_level     <= walk_level_next;
      awaiting_alloc <= awaiting_alloc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      saved_virt  <= saved_virt_next;
      saved_phys  <= saved_phys_next;
      saved_flags <= saved_flags_next;
      entry_addr  <= entry_addr_next;
    end
  end

endmodule

### rtl/core/pwt_cmdq.sv
module pwt_cmdq import pwt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic nonempty,
  output logic qfull
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t          mem [QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count;

  assign nonempty = (count != '0);
  assign qfull    = (count == (PW+1)'(QDEPTH));
  assign rd_cmd   = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wp] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_en)
        wp <= (wp == PW'(QDEPTH-1)) ? '0 : wp + PW'(1);
      if (rd_en)
        rp <= (rp == PW'(QDEPTH-1)) ? '0 : rp + PW'(1);
      count <= count + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end

endmodule

### rtl/core/pwt_back.sv
module pwt_back import pwt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_nonempty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  kind,
  output logic [51:0] mem_addr,
  output logic [63:0] write_data,
  output logic [51:0] result_addr,
  output logic [1:0]  status,
  output logic        last
);

  logic       valid;
  cmd_t       cur;
  logic [1:0] idx;
  logic       fin;
  result_t    sel;

  assign sel   = cur.r[idx];
  assign last  = (idx == cur.cnt - 2'd1);
  assign fin   = pop && valid && last;
  assign q_pop = q_nonempty && (!valid || fin);
  assign empty = !valid;

  assign kind        = sel.kind;
  assign mem_addr    = sel.mem_addr;
  assign write_data  = sel.write_data;
  assign result_addr = sel.result_addr;
  assign status      = sel.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (q_pop) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (fin) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (pop && valid) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)
      cur <= q_cmd;
  end

endmodule

### rtl/core/four_level_page_table_walker.sv
// Timing: a request or response beat is written into the command queue at the accepting
// edge; the result register is then loaded from the combinational queue head once it is
// free, and the beat's first result shows on the result ports from that register.
// Throughput: one input beat per cycle while full is low; the result side emits one beat
// per cycle while pop is held and results wait, so an item with n results needs n pops.
// Reset (rst, synchronous): walker goes idle, command queue and result register empty.
module four_level_page_table_walker import pwt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [51:0] root_table,
  input  logic [47:0] virt_addr,
  input  logic [51:0] phys_addr,
  input  logic [63:0] entry_flags,
  input  logic [63:0] read_data,
  input  logic [51:0] alloc_page,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [51:0] mem_addr,
  output logic [63:0] write_data,
  output logic [51:0] result_addr,
  output logic [1:0]  status,
  output logic        last
);

  logic accept, cmd_valid, q_pop, q_nonempty, q_full;
  cmd_t cmd, q_cmd;

  assign full   = q_full;
  assign accept = push && !full;

  pwt_front u_front (
    .clk, .rst, .accept, .op, .root_table, .virt_addr, .phys_addr,
    .entry_flags, .read_data, .alloc_page, .cmd_valid, .cmd
  );

  pwt_cmdq u_cmdq (
    .clk, .rst, .wr_en(cmd_valid), .wr_cmd(cmd), .rd_en(q_pop),
    .rd_cmd(q_cmd), .nonempty(q_nonempty), .qfull(q_full)
  );

  pwt_back u_back (
    .clk, .rst, .q_nonempty, .q_cmd, .q_pop, .pop, .empty, .kind, .mem_addr,
    .write_data, .result_addr, .status, .last
  );

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> kind == K_DONE) else $error("status off done");

  a_write_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == K_WRITE) |-> !last) else $error("write ends item");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == K_DONE) |-> last) else $error("done not last");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> empty) else $error("result after reset");

endmodule

### verif/four_level_page_table_walker_tb.sv
`timescale 1ns / 100ps

module four_level_page_table_walker_tb;
  import pwt_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [51:0] mem_addr;
    logic [63:0] write_data;
    logic [51:0] result_addr;
    logic [1:0]  status;
    logic        last;
  } walk_beat_t;

  class walk_scoreboard;
    walk_beat_t expected_beats[$];
    int errors;

    // shadow of the walker state
    bit         busy, want_page;
    logic [2:0] req_op;
    int         level;
    logic [47:0] virt;
    logic [51:0] phys;
    logic [63:0] flags;
    logic [51:0] entry_ptr;

    function void clear();
      busy = 0; want_page = 0; req_op = OP_TRANSLATE; level = 0;
      virt = '0; phys = '0; flags = '0; entry_ptr = '0;
      expected_beats.delete();
      errors = 0;
    endfunction

    function logic [51:0] slot_addr(logic [51:0] base, int lvl);
      logic [63:0] idx;
      idx = ({16'b0, virt} >> (12 + 9 * (3 - lvl))) & 64'h1FF;
      return base + 52'(idx * 8);
    endfunction

    function void add(logic [2:0] k, logic [51:0] a, logic [63:0] d,
                      logic [51:0] r, logic [1:0] s);
      walk_beat_t b;
      b = '{k, a, d, r, s, 1'b0};
      expected_beats.push_back(b);
    endfunction

    function void retire(logic [51:0] r, logic [1:0] s);
      add(K_DONE, '0, '0, r, s);
      busy = 0; want_page = 0;
    endfunction

    function void descend(logic [51:0] base);
      level++;
      entry_ptr = slot_addr(base, level);
      add(K_READ, entry_ptr, '0, '0, ST_OK);
    endfunction

    function void note_item(logic [2:0] o, logic [51:0] root, logic [47:0] va,
                            logic [51:0] pa, logic [63:0] fl, logic [63:0] rd,
                            logic [51:0] pg);
      int n0;
      logic [63:0] v;
      n0 = expected_beats.size();
      if (o <= OP_UNMAP) begin
        if (!busy) begin
          busy = 1; want_page = 0; req_op = o; virt = va; phys = pa; flags = fl;
          level = 0;
          entry_ptr = slot_addr(root, 0);
          add(K_READ, entry_ptr, '0, '0, ST_OK);
        end
      end else if (o == OP_RD_RESP) begin
        if (busy && !want_page) begin
          if (level >= 3) begin
            if (req_op == OP_TRANSLATE) begin
              if (rd[0]) retire(52'((rd & FRAME_MASK) | {52'b0, virt[11:0]}), ST_OK);
              else retire('0, ST_NOMAP);
            end else begin
              v = (req_op == OP_MAP) ? (({12'b0, phys} & FRAME_MASK) | flags) : '0;
              add(K_WRITE, entry_ptr, v, '0, ST_OK);
              retire('0, ST_OK);
            end
          end else if (rd[0]) descend(52'(rd & FRAME_MASK));
          else if (req_op == OP_MAP) begin
            want_page = 1;
            add(K_ALLOC, '0, '0, '0, ST_OK);
          end else retire('0, ST_NOMAP);
        end
      end else if (o == OP_ALLOC) begin
        if (busy && want_page) begin
          want_page = 0;
          if (pg == '0) retire('0, ST_NOMEM);
          else begin
            v = {12'b0, pg} | TABLE_FLAGS;
            add(K_CLEAR, pg, '0, '0, ST_OK);
            add(K_WRITE, entry_ptr, v, '0, ST_OK);
            descend(52'(v & FRAME_MASK));
          end
        end
      end
      if (expected_beats.size() > n0)
        expected_beats[expected_beats.size() - 1].last = 1'b1;
    endfunction

    function void check_beat(walk_beat_t got);
      walk_beat_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind); errors++;
      end
      if (got.mem_addr != want.mem_addr) begin
        $display("%0t: mem_addr exp %h got %h", $time, want.mem_addr, got.mem_addr); errors++;
      end
      if (got.write_data != want.write_data) begin
        $display("%0t: write_data exp %h got %h", $time, want.write_data, got.write_data);
        errors++;
      end
      if (got.result_addr != want.result_addr) begin
        $display("%0t: result_addr exp %h got %h", $time, want.result_addr,
                 got.result_addr);
        errors++;
      end
      if (got.status != want.status) begin
        $display("%0t: status exp %0d got %0d", $time, want.status, got.status); errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last exp %0d got %0d", $time, want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk, rst, push, pop;
  logic full, empty;
  logic [2:0] op;
  logic [51:0] root_table, phys_addr, alloc_page;
  logic [47:0] virt_addr;
  logic [63:0] entry_flags, read_data;
  logic [2:0] kind;
  logic [51:0] mem_addr, result_addr;
  logic [63:0] write_data;
  logic [1:0] status;
  logic last;

  walk_scoreboard walk_sb;
  bit stim_done;
  bit pop_quiet;

  four_level_page_table_walker dut (
    .clk, .rst, .push, .full, .op, .root_table, .virt_addr, .phys_addr, .entry_flags,
    .read_data, .alloc_page, .empty, .pop, .kind, .mem_addr, .write_data, .result_addr,
    .status, .last
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // drive one beat and hold it until accepted; push stays high for a follow-on beat,
  // so callers that pause drop it themselves
  task automatic send_item(logic [2:0] o, logic [51:0] root, logic [47:0] va,
                           logic [51:0] pa, logic [63:0] fl, logic [63:0] rd,
                           logic [51:0] pg);
    int g;
    g = gap_len();
    if (g > 0) push <= 1'b0;
    repeat (g) @(posedge clk);
    push <= 1'b1; op <= o; root_table <= root; virt_addr <= va; phys_addr <= pa;
    entry_flags <= fl; read_data <= rd; alloc_page <= pg;
    @(posedge clk);
    while (full) @(posedge clk);
    walk_sb.note_item(o, root, va, pa, fl, rd, pg);
  endtask

  task automatic send_req(logic [2:0] o, logic [51:0] root, logic [47:0] va);
    send_item(o, root, va, 52'(rand64()), rand64(), rand64(), 52'(rand64()));
  endtask

  task automatic send_rd(logic [63:0] rd);
    send_item(OP_RD_RESP, 52'(rand64()), 48'(rand64()), 52'(rand64()), rand64(), rd,
              52'(rand64()));
  endtask

  task automatic send_pg(logic [51:0] pg);
    send_item(OP_ALLOC, 52'(rand64()), 48'(rand64()), 52'(rand64()), rand64(), rand64(),
              pg);
  endtask

  function automatic logic [63:0] entry_val(bit present);
    logic [63:0] e;
    e = rand64();
    e[0] = present;
    return e;
  endfunction

  // walk one request to its end with mostly sensible responses
  task automatic run_walk();
    logic [2:0] o;
    int steps;
    o = 3'($urandom_range(0, 2));
    send_item(o, 52'(rand64()), 48'(rand64()), 52'(rand64()), rand64(), rand64(), '0);
    steps = 0;
    while (walk_sb.busy && steps < 12) begin
      if ($urandom_range(0, 15) == 0)
        send_item(3'($urandom_range(0, 7)), 52'(rand64()), 48'(rand64()), 52'(rand64()),
                  rand64(), rand64(), 52'(rand64()));
      else if (walk_sb.want_page)
        send_pg($urandom_range(0, 7) == 0 ? 52'd0 : 52'(rand64()));
      else
        send_rd(entry_val($urandom_range(0, 5) != 0));
      steps++;
    end
  endtask

  initial begin
    walk_beat_t got;
    forever begin
      @(posedge clk);
      got = '{kind, mem_addr, write_data, result_addr, status, last};
      if (!rst && pop && !empty) walk_sb.check_beat(got);
      if (pop_quiet) pop <= 1'b0;
      else if ($urandom_range(0, 19) == 0) pop <= 1'b0;
      else pop <= ($urandom_range(0, 3) != 0) || stim_done;
    end
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int waited;
    walk_sb = new();
    walk_sb.clear();
    stim_done = 0; pop_quiet = 0;
    rst <= 1'b1; push <= 1'b0; pop <= 1'b0; op <= OP_TRANSLATE;
    root_table <= '0; virt_addr <= '0; phys_addr <= '0; entry_flags <= '0;
    read_data <= '0; alloc_page <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: stray responses, extremes, full map with allocations
    send_rd('1);
    send_pg('1);
    send_item(3'd7, '1, '1, '1, '1, '1, '1);
    send_req(OP_TRANSLATE, '1, '1);
    send_req(OP_MAP, '0, '0);
    send_rd(64'hFFFF_FFFF_FFFF_FFFF);
    send_rd(64'h0);
    send_pg('1);
    send_rd(64'h0);
    send_pg(52'h1000);
    send_rd(64'h1);
    send_rd(64'h0);
    send_req(OP_UNMAP, '0, '1);
    send_rd(64'h0);
    send_req(OP_MAP, 52'h123456, 48'h8000_0000_0FFF);
    send_rd(64'h0);
    send_pg(52'h0);
    send_req(OP_UNMAP, '1, '0);
    send_rd('1); send_rd('1); send_rd('1); send_rd(64'h0);
    send_req(OP_TRANSLATE, 52'h5000, 48'hFFFF_FFFF_F123);
    send_rd('1); send_rd('1); send_rd('1); send_rd(64'h0);
    push <= 1'b0;

    // hold off until every expected beat has drained
    while (walk_sb.expected_beats.size() != 0) @(posedge clk);

    while (1) begin : rand_loop
      static int cnt = 0;
      if (cnt >= 90) break;
      if (cnt == 45) begin
        push <= 1'b0;
        pop_quiet = 1;
        repeat (40) @(posedge clk);
        pop_quiet = 0;
      end
      run_walk();
      cnt++;
    end
    push <= 1'b0;

    stim_done = 1;
    waited = 0;
    while (walk_sb.expected_beats.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (walk_sb.errors == 0 && walk_sb.expected_beats.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
